/* hdl/tfas_pkg.sv */
// shared types, constants and helper functions of the four-texel average sampler
package tfas_pkg;

    localparam int STORE_DEPTH   = 16384;
    localparam int MAX_DIMENSION = 1024;

    // fixed field widths
    localparam int IDX_W    = 14;
    localparam int CHAN_W   = 16;
    localparam int COORD_W  = 17;
    localparam int FRAC_W   = 16;
    localparam int DIM_W    = 11;
    localparam int CFG_W    = 32;
    localparam int PADDR_W  = 3;

    // derived widths
    localparam int ADDR_W    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SIZE_W    = $clog2(MAX_DIMENSION + 1);
    localparam int DIM_IDX_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
    localparam int PROD_W    = COORD_W + SIZE_W;
    localparam int FL_W      = PROD_W - FRAC_W;
    localparam int CMP_W     = FL_W + 1;
    localparam int CALC_A_W  = DIM_IDX_W + SIZE_W + 1;
    localparam int CALC_B_W  = ADDR_W + 1;
    localparam int ADDR_CALC_W = (CALC_A_W > CALC_B_W) ? CALC_A_W : CALC_B_W;
    localparam int SUM_W     = CHAN_W + 2;

    localparam int TAPS  = 4;
    localparam int TAP_W = 2;

    // opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } texel_t;

    typedef struct packed {
        logic                             opcode;
        logic [IDX_W-1:0]                 texel_index;
        texel_t                           texel;
        logic [TAPS-1:0][ADDR_CALC_W-1:0] addr;
        logic                             oob;
    } req_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic use_data;
        logic status;
    } rd_ctl_t;

    typedef struct packed {
        texel_t texel;
        logic   status;
    } res_t;

    // zero reads as one, oversize saturates
    function automatic logic [SIZE_W-1:0] eff_size(input logic [DIM_W-1:0] r);
        logic [SIZE_W-1:0] s;
        if (r == '0) begin
            s = SIZE_W'(1);
        end else if (int'(r) > MAX_DIMENSION) begin
            s = SIZE_W'(MAX_DIMENSION);
        end else begin
            s = SIZE_W'(r);
        end
        return s;
    endfunction

    function automatic logic [DIM_IDX_W-1:0] axis_clamp(input logic [CMP_W-1:0] val,
                                                        input logic [SIZE_W-1:0] size);
        logic [CMP_W-1:0] lim;
        logic [CMP_W-1:0] r;
        lim = CMP_W'(size - SIZE_W'(1));
        r   = (val > lim) ? lim : val;
        return DIM_IDX_W'(r);
    endfunction

endpackage

/* hdl/tfas_texel_mem.sv */
// single-port texel memory with registered read data
module tfas_texel_mem (
    input  logic                        aclk,
    input  logic                        en,
    input  logic                        we,
    input  logic [tfas_pkg::ADDR_W-1:0] addr,
    input  tfas_pkg::texel_t            wdata,
    output tfas_pkg::texel_t            rdata
);

    tfas_pkg::texel_t mem [tfas_pkg::STORE_DEPTH];
    tfas_pkg::texel_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/tfas_addr_gen.sv */
// three-stage pipeline from coordinates to the four texel addresses
module tfas_addr_gen (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [tfas_pkg::DIM_W-1:0]   width_in_use,
    input  logic [tfas_pkg::DIM_W-1:0]   height_in_use,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_opcode,
    input  logic [tfas_pkg::IDX_W-1:0]   in_texel_index,
    input  tfas_pkg::texel_t             in_texel,
    input  logic [tfas_pkg::COORD_W-1:0] in_u,
    input  logic [tfas_pkg::COORD_W-1:0] in_v,
    output logic                         out_valid,
    input  logic                         out_ready,
    output tfas_pkg::req_t               out_req
);

    localparam int AW = tfas_pkg::ADDR_CALC_W;

    logic [tfas_pkg::SIZE_W-1:0] w_eff;
    logic [tfas_pkg::SIZE_W-1:0] h_eff;

    // stage 1: captured transaction
    logic                         s1_valid_reg, s1_valid_next;
    logic                         s1_op_reg;
    logic [tfas_pkg::IDX_W-1:0]   s1_idx_reg;
    tfas_pkg::texel_t             s1_texel_reg;
    logic [tfas_pkg::COORD_W-1:0] s1_u_reg;
    logic [tfas_pkg::COORD_W-1:0] s1_v_reg;

    // stage 2: scaled coordinates
    logic                         s2_valid_reg, s2_valid_next;
    logic                         s2_op_reg;
    logic [tfas_pkg::IDX_W-1:0]   s2_idx_reg;
    tfas_pkg::texel_t             s2_texel_reg;
    logic [tfas_pkg::PROD_W-1:0]  s2_pu_reg;
    logic [tfas_pkg::PROD_W-1:0]  s2_pv_reg;

    // stage 3: column indices and row bases
    logic                           s3_valid_reg, s3_valid_next;
    logic                           s3_op_reg;
    logic [tfas_pkg::IDX_W-1:0]     s3_idx_reg;
    tfas_pkg::texel_t               s3_texel_reg;
    logic [tfas_pkg::DIM_IDX_W-1:0] s3_x0_reg;
    logic [tfas_pkg::DIM_IDX_W-1:0] s3_x1_reg;
    logic [AW-1:0]                  s3_b0_reg;
    logic [AW-1:0]                  s3_b1_reg;

    logic s1_free, s2_free, s3_free;

    logic [tfas_pkg::PROD_W-1:0]    pu, pv;
    logic [tfas_pkg::CMP_W-1:0]     fx, cx, fy, cy;
    logic [tfas_pkg::DIM_IDX_W-1:0] x0, x1, y0, y1;
    logic [AW-1:0]                  b0, b1;
    logic [AW-1:0]                  a0, a1, a2, a3;
    logic                           wr_oob, rd_oob;

    assign w_eff = tfas_pkg::eff_size(width_in_use);
    assign h_eff = tfas_pkg::eff_size(height_in_use);

    assign s3_free  = !s3_valid_reg || out_ready;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;

    always_comb begin
        s1_valid_next = s1_free ? in_valid     : s1_valid_reg;
        s2_valid_next = s2_free ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = s3_free ? s2_valid_reg : s3_valid_reg;
    end

    // coord * size, one multiplier per axis
    assign pu = tfas_pkg::PROD_W'(s1_u_reg) * tfas_pkg::PROD_W'(w_eff);
    assign pv = tfas_pkg::PROD_W'(s1_v_reg) * tfas_pkg::PROD_W'(h_eff);

    // floor and ceil, clamped to size-1
    always_comb begin
        fx = tfas_pkg::CMP_W'(s2_pu_reg[tfas_pkg::PROD_W-1:tfas_pkg::FRAC_W]);
        fy = tfas_pkg::CMP_W'(s2_pv_reg[tfas_pkg::PROD_W-1:tfas_pkg::FRAC_W]);
        cx = fx + tfas_pkg::CMP_W'(|s2_pu_reg[tfas_pkg::FRAC_W-1:0]);
        cy = fy + tfas_pkg::CMP_W'(|s2_pv_reg[tfas_pkg::FRAC_W-1:0]);
        x0 = tfas_pkg::axis_clamp(fx, w_eff);
        x1 = tfas_pkg::axis_clamp(cx, w_eff);
        y0 = tfas_pkg::axis_clamp(fy, h_eff);
        y1 = tfas_pkg::axis_clamp(cy, h_eff);
        b0 = AW'(y0) * AW'(w_eff);
        b1 = AW'(y1) * AW'(w_eff);
    end

    always_comb begin
        a0 = s3_b0_reg + AW'(s3_x0_reg);
        a1 = s3_b1_reg + AW'(s3_x0_reg);
        a2 = s3_b0_reg + AW'(s3_x1_reg);
        a3 = s3_b1_reg + AW'(s3_x1_reg);
        rd_oob = (a0 >= AW'(tfas_pkg::STORE_DEPTH)) || (a1 >= AW'(tfas_pkg::STORE_DEPTH)) ||
                 (a2 >= AW'(tfas_pkg::STORE_DEPTH)) || (a3 >= AW'(tfas_pkg::STORE_DEPTH));
        wr_oob = AW'(s3_idx_reg) >= AW'(tfas_pkg::STORE_DEPTH);
        out_req.opcode      = s3_op_reg;
        out_req.texel_index = s3_idx_reg;
        out_req.texel       = s3_texel_reg;
        out_req.addr[0]     = a0;
        out_req.addr[1]     = a1;
        out_req.addr[2]     = a2;
        out_req.addr[3]     = a3;
        out_req.oob         = (s3_op_reg == tfas_pkg::OP_SAMPLE) ? rd_oob : wr_oob;
    end

    assign out_valid = s3_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_free) begin
            s1_op_reg    <= in_opcode;
            s1_idx_reg   <= in_texel_index;
            s1_texel_reg <= in_texel;
            s1_u_reg     <= in_u;
            s1_v_reg     <= in_v;
        end
        if (s2_free) begin
            s2_op_reg    <= s1_op_reg;
            s2_idx_reg   <= s1_idx_reg;
            s2_texel_reg <= s1_texel_reg;
            s2_pu_reg    <= pu;
            s2_pv_reg    <= pv;
        end
        if (s3_free) begin
            s3_op_reg    <= s2_op_reg;
            s3_idx_reg   <= s2_idx_reg;
            s3_texel_reg <= s2_texel_reg;
            s3_x0_reg    <= x0;
            s3_x1_reg    <= x1;
            s3_b0_reg    <= b0;
            s3_b1_reg    <= b1;
        end
    end

endmodule

/* hdl/tfas_avg_unit.sv */
// accumulates the four texel reads and buffers results in a three-entry queue
module tfas_avg_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  tfas_pkg::rd_ctl_t ctl,
    input  tfas_pkg::texel_t  rdata,
    output logic              credit_ok,
    output logic              m_valid,
    input  logic              m_ready,
    output tfas_pkg::res_t    res
);

    localparam int SW = tfas_pkg::SUM_W;

    tfas_pkg::rd_ctl_t d_reg;
    logic [SW-1:0] acc_r_reg, acc_g_reg, acc_b_reg;
    logic [SW-1:0] sum_r, sum_g, sum_b;

    tfas_pkg::res_t ent0_reg, ent1_reg, ent2_reg;
    logic [1:0]     count_reg, count_next;
    logic           push, pop;
    logic [1:0]     slot;
    tfas_pkg::res_t res_in;

    // read data lines up with the control word in the cycle after issue
    always_comb begin
        sum_r = (d_reg.first ? '0 : acc_r_reg) + SW'(rdata.red);
        sum_g = (d_reg.first ? '0 : acc_g_reg) + SW'(rdata.green);
        sum_b = (d_reg.first ? '0 : acc_b_reg) + SW'(rdata.blue);
        res_in.status = d_reg.status;
        if (d_reg.use_data) begin
            res_in.texel.red   = sum_r[SW-1:2];
            res_in.texel.green = sum_g[SW-1:2];
            res_in.texel.blue  = sum_b[SW-1:2];
        end else begin
            res_in.texel = '0;
        end
    end

    assign push  = d_reg.valid && d_reg.last;
    assign pop   = m_valid && m_ready;
    assign slot  = count_reg - 2'(pop);
    assign count_next = count_reg + 2'(push) - 2'(pop);

    // a last access is issued only when its result will find room
    assign credit_ok = (3'(count_reg) + 3'(push)) < 3'd3;

    assign m_valid = count_reg != 2'd0;
    assign res     = ent0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg     <= '0;
            count_reg <= 2'd0;
        end else begin
            d_reg     <= ctl;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_reg.valid) begin
            acc_r_reg <= sum_r;
            acc_g_reg <= sum_g;
            acc_b_reg <= sum_b;
        end
        if (pop && count_reg >= 2'd2) begin
            ent0_reg <= ent1_reg;
        end
        if (pop && count_reg == 2'd3) begin
            ent1_reg <= ent2_reg;
        end
        if (push) begin
            if (slot == 2'd0) begin
                ent0_reg <= res_in;
            end else if (slot == 2'd1) begin
                ent1_reg <= res_in;
            end else begin
                ent2_reg <= res_in;
            end
        end
    end

endmodule

/* hdl/texture_four_texel_average_sampler.sv */
// top level: configuration registers, texel memory access sequencer and result channel
//
// Texture sampler over a 16384-entry RGB texel store held in one single-port memory.
// A write transaction stores one texel and returns a result with zero colour; a
// sample transaction reads the four texels around (u,v) and returns their per-channel
// average. The memory port sets the rate: a sample occupies it for one read per
// texel, a write or an out-of-range sample for a single issue, so writes go at
// one per cycle while the result queue has room and the output is not stalled.
// A transaction passes three address stages, the issue register, the memory stage
// and the result queue. Accesses go to memory in arrival order, so a
// sample always sees every earlier write. Texels must be written before they are
// sampled; the store is not cleared at reset. The user must see that width and
// height registers are written only while the block is idle; it is not enforced.
module texture_four_texel_average_sampler (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tfas_pkg::PADDR_W-1:0] paddr,
    input  logic [tfas_pkg::CFG_W-1:0]   pwdata,
    output logic [tfas_pkg::CFG_W-1:0]   prdata,
    output logic                         pready,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_opcode,
    input  logic [tfas_pkg::IDX_W-1:0]   s_texel_index,
    input  logic [tfas_pkg::CHAN_W-1:0]  s_red_in,
    input  logic [tfas_pkg::CHAN_W-1:0]  s_green_in,
    input  logic [tfas_pkg::CHAN_W-1:0]  s_blue_in,
    input  logic [tfas_pkg::COORD_W-1:0] s_u_coord,
    input  logic [tfas_pkg::COORD_W-1:0] s_v_coord,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tfas_pkg::CHAN_W-1:0]  m_red_out,
    output logic [tfas_pkg::CHAN_W-1:0]  m_green_out,
    output logic [tfas_pkg::CHAN_W-1:0]  m_blue_out,
    output logic                         m_status
);

    logic [tfas_pkg::DIM_W-1:0] width_reg, width_next;
    logic [tfas_pkg::DIM_W-1:0] height_reg, height_next;
    logic                       cfg_wr;

    tfas_pkg::texel_t  in_texel;
    logic              ag_valid, ag_ready;
    tfas_pkg::req_t    ag_req;

    logic                       iss_valid_reg, iss_valid_next;
    tfas_pkg::req_t             iss_req_reg;
    logic [tfas_pkg::TAP_W-1:0] tap_reg, tap_next;

    logic is_read, last, fire, finish, credit_ok;
    logic mem_en, mem_we;
    logic [tfas_pkg::ADDR_W-1:0] mem_addr;
    tfas_pkg::texel_t  mem_rdata;
    tfas_pkg::rd_ctl_t ctl;
    tfas_pkg::res_t    res;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr) begin
            unique case (paddr[2])
                tfas_pkg::REG_WIDTH:  width_next  = pwdata[tfas_pkg::DIM_W-1:0];
                tfas_pkg::REG_HEIGHT: height_next = pwdata[tfas_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            tfas_pkg::REG_WIDTH:  prdata = tfas_pkg::CFG_W'(width_reg);
            tfas_pkg::REG_HEIGHT: prdata = tfas_pkg::CFG_W'(height_reg);
            default:              prdata = '0;
        endcase
    end

    assign in_texel.red   = s_red_in;
    assign in_texel.green = s_green_in;
    assign in_texel.blue  = s_blue_in;

    tfas_addr_gen u_addr_gen (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .width_in_use   (width_reg),
        .height_in_use  (height_reg),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .in_opcode      (s_opcode),
        .in_texel_index (s_texel_index),
        .in_texel       (in_texel),
        .in_u           (s_u_coord),
        .in_v           (s_v_coord),
        .out_valid      (ag_valid),
        .out_ready      (ag_ready),
        .out_req        (ag_req)
    );

    // access sequencer: four reads per in-range sample, a single issue otherwise
    always_comb begin
        is_read  = (iss_req_reg.opcode == tfas_pkg::OP_SAMPLE) && !iss_req_reg.oob;
        last     = is_read ? (tap_reg == tfas_pkg::TAP_W'(tfas_pkg::TAPS - 1)) : 1'b1;
        fire     = iss_valid_reg && (!last || credit_ok);
        finish   = fire && last;
        ag_ready = !iss_valid_reg || finish;

        mem_we   = iss_req_reg.opcode == tfas_pkg::OP_WRITE;
        mem_en   = fire && (is_read || (mem_we && !iss_req_reg.oob));
        mem_addr = is_read ? iss_req_reg.addr[tap_reg][tfas_pkg::ADDR_W-1:0]
                           : tfas_pkg::ADDR_W'(iss_req_reg.texel_index);

        ctl.valid    = fire;
        ctl.first    = is_read ? (tap_reg == '0) : 1'b1;
        ctl.last     = last;
        ctl.use_data = is_read;
        ctl.status   = iss_req_reg.oob;

        tap_next = tap_reg;
        if (finish) begin
            tap_next = '0;
        end else if (fire) begin
            tap_next = tap_reg + tfas_pkg::TAP_W'(1);
        end

        iss_valid_next = iss_valid_reg;
        if (ag_ready) begin
            iss_valid_next = ag_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= tfas_pkg::DIM_W'(1);
            height_reg    <= tfas_pkg::DIM_W'(1);
            iss_valid_reg <= 1'b0;
            tap_reg       <= '0;
        end else begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            iss_valid_reg <= iss_valid_next;
            tap_reg       <= tap_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ag_ready) begin
            iss_req_reg <= ag_req;
        end
    end

    tfas_texel_mem u_texel_mem (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (iss_req_reg.texel),
        .rdata (mem_rdata)
    );

    tfas_avg_unit u_avg_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .rdata     (mem_rdata),
        .credit_ok (credit_ok),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .res       (res)
    );

    assign m_red_out   = res.texel.red;
    assign m_green_out = res.texel.green;
    assign m_blue_out  = res.texel.blue;
    assign m_status    = res.status;

endmodule
